// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the three-stack block.
// Each macro expands to one labeled concurrent assertion on a rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/tssa_pkg.sv =====
// Shared types and constants for the three-stack shared-memory block.
// No dependencies; imported by every module of the block but the RAM.
`default_nettype none

package tssa_pkg;

  localparam int DATA_W        = 32;
  localparam int DEFAULT_DEPTH = 64;
  localparam int QUEUE_DEPTH   = 2;
  localparam int POS_W         = 6;
  localparam int COUNT_W       = 7;

  // Operation codes on the input stream.
  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_PEEK = 2'd2;

  // Stack selector codes.
  localparam logic [1:0] SEL_LOW     = 2'd0;
  localparam logic [1:0] SEL_MIDDLE  = 2'd1;
  localparam logic [1:0] SEL_HIGH    = 2'd2;
  localparam logic [1:0] SEL_INVALID = 2'd3;

  // Classified operation as queued between front and back.
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_PEEK,
    OP_REJECT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [1:0]        sel;
    logic [DATA_W-1:0] data;
  } q_entry_t;

  typedef struct packed {
    logic               ok;
    logic [DATA_W-1:0]  data_out;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] stack_count;
    logic [COUNT_W-1:0] total_count;
  } res_t;

endpackage

`default_nettype wire

// ===== src/tssa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module tssa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/tssa_front.sv =====
// Front end: accepts input transactions, classifies them and queues them.
// Depends on tssa_pkg.
`default_nettype none

module tssa_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [31:0]         in_tdata,   // data_in[31:0]
  input  wire logic [3:0]          in_tuser,   // kind[1:0], stack_select[3:2]
  output logic                     q_valid,
  output tssa_pkg::q_entry_t       q_entry,
  input  wire logic                q_pop
);

  import tssa_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [NW-1:0] FULL_N = NW'(QUEUE_DEPTH);

  q_entry_t        entry_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]   count_r, count_nxt;
  q_entry_t        cls;
  logic            push;
  logic            pop;

  // Classify the incoming item; an invalid kind or stack id is rejected.
  always_comb begin
    cls.sel  = in_tuser[3:2];
    cls.data = in_tdata;
    case (in_tuser[1:0])
      KIND_PUSH: cls.op = OP_PUSH;
      KIND_POP:  cls.op = OP_POP;
      KIND_PEEK: cls.op = OP_PEEK;
      default:   cls.op = OP_REJECT;
    endcase
    if (in_tuser[3:2] == SEL_INVALID) begin
      cls.op = OP_REJECT;
    end
  end

  assign in_tready = (count_r != FULL_N);
  assign q_valid   = (count_r != '0);
  assign q_entry   = entry_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;

  // Queue pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

// ===== src/tssa_back.sv =====
// Back end: executes queued stack operations on the shared memory,
// shifts the middle stack when needed and holds the result register.
// Depends on tssa_pkg, tssa_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tssa_back #(
  parameter int DEPTH = tssa_pkg::DEFAULT_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  tssa_pkg::q_entry_t q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tssa_pkg::res_t     out_res
);

  import tssa_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [CW-1:0] MID_START = CW'(DEPTH / 3);
  localparam logic [CW-1:0] ONE       = CW'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_READ
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   low_r, low_nxt;
  logic [CW-1:0]   mid_r, mid_nxt;
  logic [CW-1:0]   high_r, high_nxt;
  logic [CW-1:0]   base_r, base_nxt;
  logic            sh_up_r, sh_up_nxt;
  logic [AW-1:0]   sh_rd_r, sh_rd_nxt;
  logic [AW-1:0]   sh_wr_r, sh_wr_nxt;
  logic [CW-1:0]   sh_left_r, sh_left_nxt;
  logic            sh_pend_r, sh_pend_nxt;
  res_t            pend_r, pend_nxt;
  res_t            res_r, res_nxt;
  logic            ov_r, ov_nxt;

  logic [CW-1:0]   total;
  logic [CW-1:0]   top_end;
  logic [CW-1:0]   mid_end;
  logic            full;
  logic            is_push;
  logic            is_rd;
  logic [CW-1:0]   sel_cnt;
  logic            need_up;
  logic            need_down;
  logic            slot_free;
  logic [CW-1:0]   nl, nm, nh;
  logic [CW-1:0]   new_sel_cnt;
  logic [AW-1:0]   pos;
  logic            op_ok;
  res_t            res;
  logic            inv_ok;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [DATA_W-1:0] wdata;
  logic            re;
  logic [AW-1:0]   raddr;
  logic [DATA_W-1:0] rdata;

  tssa_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  // Occupancy and the boundaries of the middle stack.
  assign total     = low_r + mid_r + high_r;
  assign top_end   = DEPTH_C - high_r;
  assign mid_end   = base_r + mid_r;
  assign full      = (total == DEPTH_C);
  assign is_push   = (q_entry.op == OP_PUSH);
  assign is_rd     = (q_entry.op == OP_POP) || (q_entry.op == OP_PEEK);
  assign slot_free = !ov_r || out_ready;

  always_comb begin
    case (q_entry.sel)
      SEL_LOW:    sel_cnt = low_r;
      SEL_MIDDLE: sel_cnt = mid_r;
      SEL_HIGH:   sel_cnt = high_r;
      default:    sel_cnt = '0;
    endcase
  end

  // A push that meets the middle stack moves it one slot away first.
  assign need_up   = is_push && !full && (q_entry.sel == SEL_LOW) && (low_r == base_r);
  assign need_down = is_push && !full && (q_entry.sel != SEL_LOW) && (mid_end == top_end);

  // Result of a plain operation, decided in the idle state.
  always_comb begin
    nl    = low_r;
    nm    = mid_r;
    nh    = high_r;
    pos   = '0;
    op_ok = 1'b0;
    if (is_push && !full) begin
      op_ok = 1'b1;
      case (q_entry.sel)
        SEL_LOW: begin
          pos = AW'(low_r);
          nl  = low_r + ONE;
        end
        SEL_MIDDLE: begin
          pos = AW'(mid_end);
          nm  = mid_r + ONE;
        end
        default: begin
          pos = AW'(top_end - ONE);
          nh  = high_r + ONE;
        end
      endcase
    end else if (is_rd && (sel_cnt != '0)) begin
      op_ok = 1'b1;
      case (q_entry.sel)
        SEL_LOW:    pos = AW'(low_r - ONE);
        SEL_MIDDLE: pos = AW'(mid_end - ONE);
        default:    pos = AW'(top_end);
      endcase
      if (q_entry.op == OP_POP) begin
        case (q_entry.sel)
          SEL_LOW:    nl = low_r - ONE;
          SEL_MIDDLE: nm = mid_r - ONE;
          default:    nh = high_r - ONE;
        endcase
      end
    end
    case (q_entry.sel)
      SEL_LOW:    new_sel_cnt = nl;
      SEL_MIDDLE: new_sel_cnt = nm;
      SEL_HIGH:   new_sel_cnt = nh;
      default:    new_sel_cnt = '0;
    endcase
    res.ok          = op_ok;
    res.data_out    = '0;
    res.position    = POS_W'(pos);
    res.stack_count = COUNT_W'(new_sel_cnt);
    res.total_count = COUNT_W'(nl + nm + nh);
  end

  // Sequencer: idle dispatch, middle-stack shift and read completion.
  always_comb begin
    state_nxt   = state_r;
    low_nxt     = low_r;
    mid_nxt     = mid_r;
    high_nxt    = high_r;
    base_nxt    = base_r;
    sh_up_nxt   = sh_up_r;
    sh_rd_nxt   = sh_rd_r;
    sh_wr_nxt   = sh_wr_r;
    sh_left_nxt = sh_left_r;
    sh_pend_nxt = sh_pend_r;
    pend_nxt    = pend_r;
    res_nxt     = res_r;
    ov_nxt      = ov_r && !out_ready;
    q_pop       = 1'b0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    re          = 1'b0;
    raddr       = '0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (need_up || need_down) begin
            // The item stays at the queue head until the shift is done.
            state_nxt   = S_SHIFT;
            sh_up_nxt   = need_up;
            sh_left_nxt = mid_r;
            sh_pend_nxt = 1'b0;
            if (need_up) begin
              sh_rd_nxt = AW'(mid_end - ONE);
              sh_wr_nxt = AW'(mid_end);
            end else begin
              sh_rd_nxt = AW'(base_r);
              sh_wr_nxt = AW'(base_r - ONE);
            end
          end else if (slot_free) begin
            q_pop    = 1'b1;
            low_nxt  = nl;
            mid_nxt  = nm;
            high_nxt = nh;
            if (is_push && op_ok) begin
              we    = 1'b1;
              waddr = pos;
              wdata = q_entry.data;
            end
            if (is_rd && op_ok) begin
              re        = 1'b1;
              raddr     = pos;
              pend_nxt  = res;
              state_nxt = S_READ;
            end else begin
              res_nxt = res;
              ov_nxt  = 1'b1;
            end
          end
        end
      end
      S_SHIFT: begin
        // Each cycle writes the word read in the previous cycle.
        if (sh_pend_r) begin
          we        = 1'b1;
          waddr     = sh_wr_r;
          wdata     = rdata;
          sh_wr_nxt = sh_up_r ? sh_wr_r - 1'b1 : sh_wr_r + 1'b1;
        end
        if (sh_left_r != '0) begin
          re          = 1'b1;
          raddr       = sh_rd_r;
          sh_rd_nxt   = sh_up_r ? sh_rd_r - 1'b1 : sh_rd_r + 1'b1;
          sh_left_nxt = sh_left_r - ONE;
          sh_pend_nxt = 1'b1;
        end else begin
          sh_pend_nxt = 1'b0;
          if (!sh_pend_r) begin
            base_nxt  = sh_up_r ? base_r + ONE : base_r - ONE;
            state_nxt = S_IDLE;
          end
        end
      end
      S_READ: begin
        // The result slot was free at dispatch, so it is free now.
        res_nxt          = pend_r;
        res_nxt.data_out = rdata;
        ov_nxt           = 1'b1;
        state_nxt        = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      low_r     <= '0;
      mid_r     <= '0;
      high_r    <= '0;
      base_r    <= MID_START;
      sh_left_r <= '0;
      sh_pend_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      low_r     <= low_nxt;
      mid_r     <= mid_nxt;
      high_r    <= high_nxt;
      base_r    <= base_nxt;
      sh_left_r <= sh_left_nxt;
      sh_pend_r <= sh_pend_nxt;
      ov_r      <= ov_nxt;
    end
    sh_up_r <= sh_up_nxt;
    sh_rd_r <= sh_rd_nxt;
    sh_wr_r <= sh_wr_nxt;
    pend_r  <= pend_nxt;
    res_r   <= res_nxt;
  end

  assign out_valid = ov_r;
  assign out_res   = res_r;

  // The three stacks never overlap and never exceed the memory.
  assign inv_ok = (low_r <= base_r) && ((base_r + mid_r + high_r) <= DEPTH_C);

  `ASSERT_ALWAYS(a_layout_ok, clk, rst_n, inv_ok)
  `ASSERT_NEXT(a_no_result_in_shift, clk, rst_n, state_r == S_SHIFT, !$rose(ov_r))
  `ASSERT_NEXT(a_read_gives_result, clk, rst_n, state_r == S_READ, ov_r)

endmodule

`default_nettype wire

// ===== src/three_stacks_shared_array_top.sv =====
// A push result passes the input queue and the result register; pop and peek results
// also pass the registered memory read. One push per cycle while the result is taken
// and no shift is needed; a pop or peek holds the next item back until its read is done,
// and a push that meets the middle stack first waits for the element-by-element shift.
// Reset: synchronous, active low; counts clear, the middle base returns to DEPTH/3,
// the queue and result register empty; the memory itself is not cleared.
`default_nettype none

module three_stacks_shared_array_top #(
  parameter int DEPTH = tssa_pkg::DEFAULT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // data_in[31:0]
  input  wire logic [3:0]  in_tuser,    // kind[1:0], stack_select[3:2]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,   // data_out[31:0], position[37:32],
                                        // stack_count[44:38], total_count[51:45]
  output logic [0:0]       out_tuser    // ok[0]
);

  import tssa_pkg::*;

  logic     q_valid;
  q_entry_t q_entry;
  logic     q_pop;
  res_t     res;

  tssa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop)
  );

  tssa_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result fields onto the output stream.
  assign out_tdata = {4'b0, res.total_count, res.stack_count, res.position, res.data_out};
  assign out_tuser = res.ok;

endmodule

`default_nettype wire
